// ===== rtl/phw_pkg.sv =====
`timescale 1ns / 1ps
package phw_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [10:0] record_offset;
    logic [11:0] record_length;
    logic [15:0] next_protocol;
    logic        truncated;
    logic        last_record;
  } out_item_t;

  // Byte slots fetched around the current header before it is decoded.
  localparam logic [2:0] SL_B0  = 3'd0;
  localparam logic [2:0] SL_B2  = 3'd1;
  localparam logic [2:0] SL_B3  = 3'd2;
  localparam logic [2:0] SL_B4  = 3'd3;
  localparam logic [2:0] SL_B9  = 3'd4;
  localparam logic [2:0] SL_B12 = 3'd5;
  localparam logic [2:0] SL_B13 = 3'd6;
  localparam int FETCH_SLOTS = 7;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic walk_end;
  } dp_stat_t;

  localparam logic [3:0] K_ETH  = 4'd0;
  localparam logic [3:0] K_VLAN = 4'd1;
  localparam logic [3:0] K_MPLS = 4'd2;
  localparam logic [3:0] K_PW   = 4'd3;
  localparam logic [3:0] K_ARP  = 4'd4;
  localparam logic [3:0] K_IP   = 4'd5;
  localparam logic [3:0] K_GRE  = 4'd6;
  localparam logic [3:0] K_ICMP = 4'd7;
  localparam logic [3:0] K_TCP  = 4'd8;
  localparam logic [3:0] K_UDP  = 4'd9;
  localparam logic [3:0] K_PAY  = 4'd10;

  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ETYPE_ARP     = 16'h0806;
  localparam logic [15:0] ETYPE_VLAN    = 16'h8100;
  localparam logic [15:0] ETYPE_MPLS_UC = 16'h8847;
  localparam logic [15:0] ETYPE_MPLS_MC = 16'h8848;
  localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;

  localparam logic [15:0] PROTO_ICMP = 16'd1;
  localparam logic [15:0] PROTO_IPIP = 16'd4;
  localparam logic [15:0] PROTO_TCP  = 16'd6;
  localparam logic [15:0] PROTO_UDP  = 16'd17;
  localparam logic [15:0] PROTO_GRE  = 16'd47;

  localparam logic [3:0] NIB_IPV4 = 4'd4;
  localparam logic [3:0] NIB_IPV6 = 4'd6;

  function automatic logic [3:0] fetch_rel(input logic [2:0] sel);
    logic [3:0] r;
    case (sel)
      SL_B0:   r = 4'd0;
      SL_B2:   r = 4'd2;
      SL_B3:   r = 4'd3;
      SL_B4:   r = 4'd4;
      SL_B9:   r = 4'd9;
      SL_B12:  r = 4'd12;
      SL_B13:  r = 4'd13;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/phw_ctrl.sv =====
`timescale 1ns / 1ps
module phw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_eop,
  output logic              in_ready,
  input  phw_pkg::dp_stat_t stat,
  output phw_pkg::dp_cmd_t  cmd
);
  import phw_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD   = 4'b0001,
    S_FETCH  = 4'b0010,
    S_WAIT   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] k_r, k_nxt;

  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    cmd        = '0;
    cmd.rd_sel = k_r;
    case (state_r)
      S_LOAD: begin
        cmd.load = in_valid;
        k_nxt    = '0;
        if (in_valid && in_eop) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_en = 1'b1;
        k_nxt     = k_r + 3'd1;
        if (k_r == 3'(FETCH_SLOTS - 1)) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        k_nxt = '0;
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.walk_end ? S_LOAD : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ===== rtl/phw_datapath.sv =====
`timescale 1ns / 1ps
module phw_datapath #(
  parameter int MAX_PACKET  = 2048,
  parameter int MAX_RECORDS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  phw_pkg::dp_cmd_t   cmd,
  output phw_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output phw_pkg::out_item_t out_data
);
  import phw_pkg::*;

  localparam int CAP  = (MAX_RECORDS < 16) ? MAX_RECORDS : 16;
  localparam int CNTW = $clog2(CAP);
  localparam int AW   = $clog2(MAX_PACKET);
  localparam int BW   = $clog2(MAX_PACKET + 1);
  localparam int OW   = $clog2(MAX_PACKET + 1024) + 1;
  localparam int CW   = (OW > 16) ? OW : 16;

  typedef enum logic [3:0] {
    M_ETH   = 4'b0001,
    M_ETYPE = 4'b0010,
    M_IPP   = 4'b0100,
    M_PW    = 4'b1000
  } mode_t;

  logic [7:0]      mem [MAX_PACKET];
  logic [7:0]      mem_q;
  logic            inr_q;
  logic            cap_r;
  logic [2:0]      sel_r;
  logic [7:0]      bytes_r [FETCH_SLOTS];

  logic [BW-1:0]   bl_r, bl_nxt;
  logic [OW-1:0]   walk_r, walk_nxt;
  logic [15:0]     cur_r, cur_nxt;
  mode_t           mode_r, mode_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            ov_r, ov_nxt;
  out_item_t       out_r;

  logic [OW-1:0]   pos;
  logic [OW-1:0]   bl_ext;
  logic [OW-1:0]   left;
  logic [3:0]      kind;
  logic [OW-1:0]   len;
  logic [6:0]      span;
  logic [6:0]      adv;
  logic [15:0]     nx;
  logic            fail;
  logic            stop;
  logic            trunc;
  logic            last;
  logic [5:0]      hl;
  logic [4:0]      gl;
  logic [15:0]     b23;
  logic [3:0]      nib;

  assign bl_ext = OW'(bl_r);
  assign pos    = walk_r + OW'(fetch_rel(cmd.rd_sel));
  assign left   = (bl_ext > walk_r) ? (bl_ext - walk_r) : '0;
  assign b23    = {bytes_r[SL_B2], bytes_r[SL_B3]};
  assign nib    = bytes_r[SL_B4][7:4];

  always_ff @(posedge clk) begin
    if (cmd.load && (bl_r < BW'(MAX_PACKET))) begin
      mem[bl_r[AW-1:0]] <= in_byte;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[pos[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    inr_q <= pos < bl_ext;
    sel_r <= cmd.rd_sel;
    if (cap_r) begin
      bytes_r[sel_r] <= inr_q ? mem_q : 8'd0;
    end
  end

  always_comb begin
    kind  = K_PAY;
    len   = '0;
    span  = '0;
    adv   = '0;
    nx    = '0;
    fail  = 1'b0;
    stop  = 1'b0;
    hl    = {bytes_r[SL_B0][3:0], 2'b00};
    gl    = 5'd4 + {2'b00, bytes_r[SL_B0][7], 2'b00} + {2'b00, bytes_r[SL_B0][5], 2'b00}
            + {2'b00, bytes_r[SL_B0][4], 2'b00};
    mode_nxt = M_ETYPE;
    cur_nxt  = cur_r;
    case (mode_r)
      M_ETH:   kind = K_ETH;
      M_PW:    kind = K_PW;
      M_ETYPE: begin
        case (cur_r) inside
          ETYPE_IPV4:                   kind = K_IP;
          ETYPE_ARP:                    kind = K_ARP;
          ETYPE_VLAN:                   kind = K_VLAN;
          ETYPE_MPLS_UC, ETYPE_MPLS_MC: kind = K_MPLS;
          default:                      kind = K_PAY;
        endcase
      end
      M_IPP: begin
        case (cur_r) inside
          PROTO_IPIP: kind = K_IP;
          PROTO_GRE:  kind = K_GRE;
          PROTO_ICMP: kind = K_ICMP;
          PROTO_TCP:  kind = K_TCP;
          PROTO_UDP:  kind = K_UDP;
          default:    kind = K_PAY;
        endcase
      end
      default: kind = K_PAY;
    endcase
    case (kind)
      K_ETH: begin
        len     = OW'(14);
        span    = 7'd14;
        adv     = 7'd14;
        nx      = {bytes_r[SL_B12], bytes_r[SL_B13]};
        cur_nxt = nx;
      end
      K_VLAN: begin
        len     = OW'(4);
        span    = 7'd4;
        adv     = 7'd4;
        nx      = b23;
        fail    = left <= OW'(4);
        stop    = fail;
        cur_nxt = nx;
      end
      K_MPLS: begin
        len  = OW'(4);
        span = 7'd4;
        adv  = 7'd4;
        if (!bytes_r[SL_B2][0]) begin
          nx = ETYPE_MPLS_UC;
        end else begin
          fail = (walk_r + OW'(4)) >= bl_ext;
          if (nib == NIB_IPV4) begin
            nx = ETYPE_IPV4;
          end else if (nib == NIB_IPV6) begin
            nx = ETYPE_IPV6;
          end else begin
            nx = '0;
          end
        end
        cur_nxt = nx;
        if (nx == '0) begin
          mode_nxt = M_PW;
        end
      end
      K_PW: begin
        len      = OW'(4);
        span     = 7'd4;
        adv      = 7'd4;
        mode_nxt = M_ETH;
      end
      K_ARP: begin
        len      = OW'(28);
        span     = 7'd28;
        adv      = 7'd28;
        stop     = (walk_r + OW'(28)) >= bl_ext;
        cur_nxt  = '0;
        mode_nxt = M_IPP;
      end
      K_IP: begin
        len      = OW'(hl);
        span     = (hl < 6'd20) ? 7'd20 : 7'(hl);
        adv      = 7'(hl);
        nx       = {8'd0, bytes_r[SL_B9]};
        fail     = (bytes_r[SL_B0][3:0] < 4'd5) || (CW'(left) < CW'(b23));
        stop     = fail;
        cur_nxt  = nx;
        mode_nxt = M_IPP;
      end
      K_GRE: begin
        len     = OW'(gl);
        span    = 7'(gl);
        adv     = 7'(gl);
        nx      = b23;
        fail    = left <= OW'(gl);
        stop    = fail;
        cur_nxt = nx;
      end
      K_ICMP, K_UDP: begin
        len      = OW'(8);
        span     = 7'd8;
        adv      = 7'd8;
        cur_nxt  = '0;
        mode_nxt = M_IPP;
      end
      K_TCP: begin
        hl       = {bytes_r[SL_B12][7:4], 2'b00};
        len      = OW'(hl);
        span     = (hl < 6'd20) ? 7'd20 : 7'(hl);
        adv      = 7'(hl);
        fail     = bytes_r[SL_B12][7:4] < 4'd5;
        stop     = fail;
        cur_nxt  = '0;
        mode_nxt = M_IPP;
      end
      default: begin
        len  = left;
        fail = walk_r > bl_ext;
        stop = 1'b1;
      end
    endcase
    trunc = fail || ((walk_r + OW'(span)) > bl_ext);
    last  = stop || (cnt_r == CNTW'(CAP - 1));
  end

  assign stat.slot_free = !ov_r || out_ready;
  assign stat.walk_end  = last;

  always_comb begin
    bl_nxt   = bl_r;
    walk_nxt = walk_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r && !out_ready;
    if (cmd.load && (bl_r < BW'(MAX_PACKET))) begin
      bl_nxt = bl_r + BW'(1);
    end
    if (cmd.emit) begin
      ov_nxt = 1'b1;
      if (last) begin
        bl_nxt   = '0;
        walk_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        walk_nxt = walk_r + OW'(adv);
        cnt_nxt  = cnt_r + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_r   <= '0;
      walk_r <= '0;
      cur_r  <= '0;
      mode_r <= M_ETH;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
      cap_r  <= 1'b0;
    end else begin
      bl_r   <= bl_nxt;
      walk_r <= walk_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
      cap_r  <= cmd.rd_en;
      if (cmd.emit) begin
        cur_r  <= last ? 16'd0 : cur_nxt;
        mode_r <= last ? M_ETH : mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.record_kind   <= kind;
      out_r.record_offset <= walk_r[10:0];
      out_r.record_length <= len[11:0];
      out_r.next_protocol <= nx;
      out_r.truncated     <= trunc;
      out_r.last_record   <= last;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/packet_header_walker.sv =====
`timescale 1ns / 1ps
// Takes one packet a byte per cycle into an internal buffer; after the byte
// flagged end_of_packet it walks the header chain and emits one record per
// header, the final one flagged last_record. Bytes beyond MAX_PACKET are
// dropped and at most MAX_RECORDS (and no more than 16) records are given.
// Each header is then handled in order, set by the single buffer read port:
// seven byte fetches, a wait for the read data to settle and one decode
// step that also loads the output register; that step stalls while the
// previous record still waits in that register. No byte is taken during
// the walk.
module packet_header_walker #(
  parameter int MAX_PACKET  = 2048,
  parameter int MAX_RECORDS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  phw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output phw_pkg::out_item_t out_data
);
  import phw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  phw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_eop   (in_data.end_of_packet),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  phw_datapath #(
    .MAX_PACKET  (MAX_PACKET),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_data.data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/tb_packet_header_walker.sv =====
`timescale 1ns / 1ps
module tb_packet_header_walker;
  import phw_pkg::*;

  localparam int STORE_DEPTH = 2048;
  localparam int RECORD_CAP = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  packet_header_walker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  out_item_t expected_records[$];
  logic [7:0] packet_copy [0:STORE_DEPTH-1];
  logic [7:0] pkt_bytes [0:1023];
  int unsigned copy_count = 0;
  int unsigned walk_pos;
  int unsigned walk_records;
  int errors = 0;
  int cycles = 0;
  bit send_idles = 1'b1;
  bit recv_idles = 1'b1;

  function automatic int unsigned peek8(input int unsigned p);
    return (p < copy_count) ? int'(packet_copy[p]) : 0;
  endfunction

  function automatic int unsigned peek16(input int unsigned p);
    return (peek8(p) << 8) | peek8(p + 1);
  endfunction

  function automatic int unsigned bytes_left();
    return (copy_count > walk_pos) ? copy_count - walk_pos : 0;
  endfunction

  function automatic logic [3:0] header_kind(input bit ip_space, input int unsigned p);
    if (ip_space) begin
      case (p)
        int'(PROTO_IPIP): return K_IP;
        int'(PROTO_GRE):  return K_GRE;
        int'(PROTO_ICMP): return K_ICMP;
        int'(PROTO_TCP):  return K_TCP;
        int'(PROTO_UDP):  return K_UDP;
        default:          return K_PAY;
      endcase
    end
    case (p)
      int'(ETYPE_IPV4):                         return K_IP;
      int'(ETYPE_ARP):                          return K_ARP;
      int'(ETYPE_VLAN):                         return K_VLAN;
      int'(ETYPE_MPLS_UC), int'(ETYPE_MPLS_MC): return K_MPLS;
      default:                                  return K_PAY;
    endcase
  endfunction

  function automatic bit add_record(input logic [3:0] kind, input int unsigned len,
                                    input int unsigned span, input int unsigned nx,
                                    input bit trunc);
    out_item_t r;
    if (walk_pos + span > copy_count) trunc = 1'b1;
    r.record_kind = kind;
    r.record_offset = walk_pos[10:0];
    r.record_length = len[11:0];
    r.next_protocol = nx[15:0];
    r.truncated = trunc;
    r.last_record = 1'b0;
    expected_records.push_back(r);
    walk_records++;
    return walk_records >= RECORD_CAP;
  endfunction

  function automatic void walk_headers();
    logic [3:0] kind;
    bit ip_space;
    bit fail;
    int unsigned cur, nx, nib, hl, tot, b0, gl, doff;
    ip_space = 1'b0;
    cur = peek16(walk_pos + 12);
    if (add_record(K_ETH, 14, 14, cur, 1'b0)) return;
    walk_pos += 14;
    forever begin
      kind = header_kind(ip_space, cur);
      ip_space = 1'b0;
      case (kind)
        K_VLAN: begin
          nx = peek16(walk_pos + 2);
          fail = bytes_left() <= 4;
          if (add_record(K_VLAN, 4, 4, nx, fail) || fail) return;
          walk_pos += 4;
          cur = nx;
        end
        K_MPLS: begin
          if ((peek8(walk_pos + 2) & 1) == 0) begin
            if (add_record(K_MPLS, 4, 4, 32'(ETYPE_MPLS_UC), 1'b0)) return;
            walk_pos += 4;
            cur = 32'(ETYPE_MPLS_UC);
          end else begin
            nib = peek8(walk_pos + 4) >> 4;
            nx = (nib == 32'(NIB_IPV4)) ? 32'(ETYPE_IPV4) :
                 ((nib == 32'(NIB_IPV6)) ? 32'(ETYPE_IPV6) : 0);
            if (add_record(K_MPLS, 4, 4, nx, walk_pos + 4 >= copy_count)) return;
            walk_pos += 4;
            if (nx != 0) begin
              cur = nx;
            end else begin
              if (add_record(K_PW, 4, 4, 0, 1'b0)) return;
              walk_pos += 4;
              cur = peek16(walk_pos + 12);
              if (add_record(K_ETH, 14, 14, cur, 1'b0)) return;
              walk_pos += 14;
            end
          end
        end
        K_ARP: begin
          if (add_record(K_ARP, 28, 28, 0, 1'b0)) return;
          walk_pos += 28;
          if (bytes_left() == 0) return;
          cur = 0;
          ip_space = 1'b1;
        end
        K_IP: begin
          hl = (peek8(walk_pos) & 15) * 4;
          tot = peek16(walk_pos + 2);
          nx = peek8(walk_pos + 9);
          fail = (hl < 20) || (bytes_left() < tot);
          if (add_record(K_IP, hl, (hl < 20) ? 20 : hl, nx, fail) || fail) return;
          walk_pos += hl;
          cur = nx;
          ip_space = 1'b1;
        end
        K_GRE: begin
          b0 = peek8(walk_pos);
          gl = 4 + 4 * (((b0 >> 7) & 1) + ((b0 >> 5) & 1) + ((b0 >> 4) & 1));
          nx = peek16(walk_pos + 2);
          fail = bytes_left() <= gl;
          if (add_record(K_GRE, gl, gl, nx, fail) || fail) return;
          walk_pos += gl;
          cur = nx;
        end
        K_ICMP, K_UDP: begin
          if (add_record(kind, 8, 8, 0, 1'b0)) return;
          walk_pos += 8;
          cur = 0;
          ip_space = 1'b1;
        end
        K_TCP: begin
          doff = peek8(walk_pos + 12) >> 4;
          hl = doff * 4;
          fail = doff < 5;
          if (add_record(K_TCP, hl, (hl < 20) ? 20 : hl, 0, fail) || fail) return;
          walk_pos += hl;
          cur = 0;
          ip_space = 1'b1;
        end
        default: begin
          void'(add_record(K_PAY, bytes_left(), 0, 0, walk_pos > copy_count));
          return;
        end
      endcase
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eop);
    if (send_idles && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, end_of_packet: eop};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (copy_count < STORE_DEPTH) begin
      packet_copy[copy_count] = b;
      copy_count++;
    end
    if (eop) begin
      walk_pos = 0;
      walk_records = 0;
      walk_headers();
      expected_records[expected_records.size() - 1].last_record = 1'b1;
      copy_count = 0;
    end
  endtask

  task automatic send_packet(input int len);
    for (int i = 0; i < len; i++) send_byte(pkt_bytes[i], i == len - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic put16(input int p, input logic [15:0] v);
    pkt_bytes[p] = v[15:8];
    pkt_bytes[p + 1] = v[7:0];
  endtask

  function automatic logic [15:0] pick_ethertype();
    case ($urandom_range(0, 7))
      0: return ETYPE_IPV4;
      1: return ETYPE_ARP;
      2: return ETYPE_VLAN;
      3: return ETYPE_MPLS_UC;
      4: return ETYPE_MPLS_MC;
      5: return ETYPE_IPV6;
      6: return ETYPE_IPV4;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_ip_proto();
    case ($urandom_range(0, 6))
      0: return PROTO_ICMP[7:0];
      1: return PROTO_IPIP[7:0];
      2: return PROTO_TCP[7:0];
      3: return PROTO_UDP[7:0];
      4: return PROTO_GRE[7:0];
      5: return PROTO_TCP[7:0];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_chain(output int len);
    int pos, steps, ihl, doff, gl;
    logic [15:0] t;
    logic [3:0] kind, nib;
    logic [7:0] b0;
    bit ip_space, done;
    for (int i = 0; i < 1024; i++) pkt_bytes[i] = 8'($urandom_range(0, 255));
    t = pick_ethertype();
    put16(12, t);
    pos = 14;
    ip_space = 1'b0;
    done = 1'b0;
    steps = 0;
    while (!done && steps < 10) begin
      steps++;
      kind = header_kind(ip_space, t);
      ip_space = 1'b0;
      case (kind)
        K_VLAN: begin
          t = pick_ethertype();
          put16(pos + 2, t);
          pos += 4;
        end
        K_MPLS: begin
          if ($urandom_range(0, 2) == 0) begin
            pkt_bytes[pos + 2][0] = 1'b0;
            pos += 4;
          end else begin
            pkt_bytes[pos + 2][0] = 1'b1;
            case ($urandom_range(0, 3))
              0: nib = NIB_IPV4;
              1: nib = NIB_IPV6;
              2: nib = 4'd0;
              default: nib = 4'($urandom_range(0, 15));
            endcase
            pkt_bytes[pos + 4][7:4] = nib;
            pos += 4;
            if (nib == NIB_IPV4) begin
              t = ETYPE_IPV4;
            end else if (nib == NIB_IPV6) begin
              done = 1'b1;
            end else begin
              pos += 4;
              t = pick_ethertype();
              put16(pos + 12, t);
              pos += 14;
            end
          end
        end
        K_ARP: begin
          pos += 28;
          done = 1'b1;
        end
        K_IP: begin
          ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 7);
          pkt_bytes[pos] = {4'd4, ihl[3:0]};
          if ($urandom_range(0, 7) == 0) put16(pos + 2, 16'($urandom_range(0, 65535)));
          else put16(pos + 2, 16'(ihl * 4 + $urandom_range(0, 20)));
          t = {8'd0, pick_ip_proto()};
          pkt_bytes[pos + 9] = t[7:0];
          if (ihl < 5) done = 1'b1;
          pos += ihl * 4;
          ip_space = 1'b1;
        end
        K_GRE: begin
          b0 = 8'($urandom_range(0, 255));
          pkt_bytes[pos] = b0;
          gl = 4 + 4 * (b0[7] + b0[5] + b0[4]);
          t = pick_ethertype();
          put16(pos + 2, t);
          pos += gl;
        end
        K_TCP: begin
          doff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 8);
          pkt_bytes[pos + 12][7:4] = doff[3:0];
          pos += (doff < 5) ? 20 : doff * 4;
          done = 1'b1;
        end
        K_ICMP, K_UDP: begin
          pos += 8;
          done = 1'b1;
        end
        default: done = 1'b1;
      endcase
    end
    if ($urandom_range(0, 7) == 0) len = $urandom_range(1, pos);
    else len = pos + $urandom_range(0, 40);
    if (len > 1024) len = 1024;
  endtask

  task automatic report_field(input string name, input int e, input int a);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_packet_header_walker NOT OK");
      $finish;
    end else begin
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          e = expected_records.pop_front();
          if (out_data.record_kind !== e.record_kind)
            report_field("record_kind", e.record_kind, out_data.record_kind);
          if (out_data.record_offset !== e.record_offset)
            report_field("record_offset", e.record_offset, out_data.record_offset);
          if (out_data.record_length !== e.record_length)
            report_field("record_length", e.record_length, out_data.record_length);
          if (out_data.next_protocol !== e.next_protocol)
            report_field("next_protocol", e.next_protocol, out_data.next_protocol);
          if (out_data.truncated !== e.truncated)
            report_field("truncated", e.truncated, out_data.truncated);
          if (out_data.last_record !== e.last_record)
            report_field("last_record", e.last_record, out_data.last_record);
        end
      end
      out_ready <= (!recv_idles) || ($urandom_range(0, 99) >= 24);
    end
  end

  task automatic test_short_packets();
    pkt_bytes[0] = 8'hFF;
    send_packet(1);
    pkt_bytes[0] = 8'h00;
    send_packet(1);
    for (int i = 0; i < 14; i++) pkt_bytes[i] = 8'h00;
    send_packet(14);
  endtask

  task automatic test_arp_at_end();
    for (int i = 0; i < 42; i++) pkt_bytes[i] = 8'($urandom_range(0, 255));
    put16(12, ETYPE_ARP);
    send_packet(42);
  endtask

  task automatic test_record_cap();
    send_idles = 1'b0;
    recv_idles = 1'b0;
    for (int i = 0; i < 120; i++) pkt_bytes[i] = 8'($urandom_range(0, 255));
    put16(12, ETYPE_VLAN);
    for (int i = 0; i < 20; i++) put16(14 + 4 * i + 2, ETYPE_VLAN);
    send_packet(80);
    send_idles = 1'b1;
    recv_idles = 1'b1;
  endtask

  task automatic test_random_chains();
    int sent, len;
    sent = 0;
    while (sent < 80) begin
      build_chain(len);
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < len; i++) pkt_bytes[i] = 8'($urandom_range(0, 255));
      end
      send_packet(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_packets();
    test_arp_at_end();
    test_record_cap();
    wait_drained();
    test_random_chains();
    wait_drained();
    if (expected_records.size() != 0) begin
      $display("%0t: records missing, expected %0d more, actual 0", $time,
               expected_records.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_packet_header_walker OK");
    end else begin
      $display("tb_packet_header_walker NOT OK");
    end
    $finish;
  end

endmodule
